// ===== sv/cptp_pkg.sv =====
package cptp_pkg;

  localparam int FRAC_DIGITS = 6;
  localparam int SCALE       = 10 ** FRAC_DIGITS;
  localparam int FRAC_W      = $clog2(SCALE);
  localparam int FCNT_W      = $clog2(FRAC_DIGITS + 1);

  localparam int WHOLE_W     = 15;
  localparam int WHOLE_SAT   = 32767;
  localparam int LIM_W       = 8;
  localparam int LAT_LIMIT   = 90;
  localparam int LON_LIMIT   = 180;

  localparam int LAT_W       = 28;
  localparam int LON_W       = 29;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    CK_SPACE,
    CK_SIGN,
    CK_DIGIT,
    CK_POINT,
    CK_OTHER,
    CK_EOL
  } cptp_kind_t;

  typedef struct packed {
    cptp_kind_t  kind;
    logic        minus;
    logic [3:0]  digit;
  } cptp_item_t;

  // Weight of the fraction digit at position k (0 is the first after the point).
  function automatic logic [FRAC_W-1:0] place_value(input logic [FCNT_W-1:0] k);
    logic [FRAC_W-1:0] v;
    v = FRAC_W'(1);
    for (int i = 0; i < FRAC_DIGITS - 1; i++) begin
      if (i >= int'(k)) begin
        v = FRAC_W'(v * FRAC_W'(10));
      end
    end
    return v;
  endfunction

endpackage

// ===== sv/cptp_front.sv =====
module cptp_front
  import cptp_pkg::*;
(
  input  logic       in_valid,
  input  logic [7:0] in_character,
  input  logic       in_end_of_line,
  output logic       in_stall,
  input  logic       q_full,
  output logic       q_push,
  output cptp_item_t q_item
);

  logic [7:0] digit_code;

  assign in_stall   = q_full;
  assign q_push     = in_valid && !q_full;
  assign digit_code = in_character - CH_ZERO;

  always_comb begin
    q_item.minus = (in_character == CH_MINUS);
    q_item.digit = digit_code[3:0];
    if (in_end_of_line) begin
      q_item.kind = CK_EOL;
    end else if (in_character == CH_SPACE) begin
      q_item.kind = CK_SPACE;
    end else if (in_character == CH_PLUS || in_character == CH_MINUS) begin
      q_item.kind = CK_SIGN;
    end else if (in_character >= CH_ZERO && in_character <= CH_NINE) begin
      q_item.kind = CK_DIGIT;
    end else if (in_character == CH_POINT) begin
      q_item.kind = CK_POINT;
    end else begin
      q_item.kind = CK_OTHER;
    end
  end

endmodule

// ===== sv/cptp_queue.sv =====
module cptp_queue
  import cptp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cptp_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output cptp_item_t head_item
);

  cptp_item_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/cptp_back.sv =====
module cptp_back
  import cptp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  cptp_item_t              q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_valid_res,
  output logic signed [LAT_W-1:0] out_latitude,
  output logic signed [LON_W-1:0] out_longitude
);

  typedef enum logic [5:0] {
    PH_BETWEEN = 6'b000001,
    PH_SIGN    = 6'b000010,
    PH_WHOLE   = 6'b000100,
    PH_POINT   = 6'b001000,
    PH_FRAC    = 6'b010000,
    PH_BAD     = 6'b100000
  } cptp_phase_t;

  cptp_phase_t        phase_r, phase_nxt;
  logic [1:0]         count_r, count_nxt;
  logic               minus_r, minus_nxt;
  logic [WHOLE_W-1:0] whole_r, whole_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [FCNT_W-1:0]  fcnt_r, fcnt_nxt;
  logic               err_r, err_nxt;

  logic [LIM_W-1:0]   sav_whole_r, sav_whole_nxt;
  logic [FRAC_W-1:0]  sav_frac_r, sav_frac_nxt;
  logic               sav_minus_r, sav_minus_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               res_r, res_nxt;
  logic [LAT_W-1:0]   lat_r, lat_nxt;
  logic [LON_W-1:0]   lon_r, lon_nxt;

  logic               out_ready;
  logic [LIM_W-1:0]   limit;
  logic               fin_err;
  logic               fin_lat;
  logic               line_ok;
  logic [WHOLE_W+4:0] whole_x10;
  logic [FRAC_W-1:0]  frac_add;
  logic [LAT_W-1:0]   lat_mag;
  logic [LON_W-1:0]   lon_mag;

  assign out_valid     = out_valid_r;
  assign out_valid_res = res_r;
  assign out_latitude  = lat_r;
  assign out_longitude = lon_r;

  assign out_ready = !out_valid_r || !out_stall;
  assign q_pop     = q_valid && (q_item.kind != CK_EOL || out_ready);

  // The range test compares the whole part with the limit: a value at the limit is
  // only out of range when it also carries a non-zero fraction.
  always_comb begin
    limit   = (count_r == 2'd1) ? LIM_W'(LAT_LIMIT) : LIM_W'(LON_LIMIT);
    fin_err = (phase_r == PH_SIGN) || (phase_r == PH_BAD) ||
              (whole_r > WHOLE_W'(limit)) ||
              ((whole_r == WHOLE_W'(limit)) && (frac_r != '0));
    fin_lat = (count_r == 2'd1) && !fin_err;
    line_ok = !err_r && (count_r == 2'd2) &&
              ((phase_r == PH_BETWEEN) || !fin_err);
    whole_x10 = (WHOLE_W+5)'(whole_r) * (WHOLE_W+5)'(10) + (WHOLE_W+5)'(q_item.digit);
    frac_add  = FRAC_W'(place_value(fcnt_r) * FRAC_W'(q_item.digit));
    lat_mag   = LAT_W'(sav_whole_r) * LAT_W'(SCALE) + LAT_W'(sav_frac_r);
    lon_mag   = LON_W'(whole_r[LIM_W-1:0]) * LON_W'(SCALE) + LON_W'(frac_r);
  end

  always_comb begin
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    minus_nxt     = minus_r;
    whole_nxt     = whole_r;
    frac_nxt      = frac_r;
    fcnt_nxt      = fcnt_r;
    err_nxt       = err_r;
    sav_whole_nxt = sav_whole_r;
    sav_frac_nxt  = sav_frac_r;
    sav_minus_nxt = sav_minus_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt       = res_r;
    lat_nxt       = lat_r;
    lon_nxt       = lon_r;

    if (q_pop) begin
      if (q_item.kind == CK_EOL) begin
        out_valid_nxt = 1'b1;
        res_nxt       = line_ok;
        lat_nxt       = line_ok ? (sav_minus_r ? -lat_mag : lat_mag) : '0;
        lon_nxt       = line_ok ? (minus_r ? -lon_mag : lon_mag) : '0;
        phase_nxt     = PH_BETWEEN;
        count_nxt     = '0;
        minus_nxt     = 1'b0;
        whole_nxt     = '0;
        frac_nxt      = '0;
        fcnt_nxt      = '0;
        err_nxt       = 1'b0;
        sav_whole_nxt = '0;
        sav_frac_nxt  = '0;
        sav_minus_nxt = 1'b0;
      end else if (q_item.kind == CK_SPACE) begin
        if (phase_r != PH_BETWEEN) begin
          if (fin_err) begin
            err_nxt = 1'b1;
          end
          if (fin_lat) begin
            sav_whole_nxt = whole_r[LIM_W-1:0];
            sav_frac_nxt  = frac_r;
            sav_minus_nxt = minus_r;
          end
          phase_nxt = PH_BETWEEN;
        end
      end else begin
        case (phase_r)
          PH_BETWEEN: begin
            if (count_r != 2'd3) begin
              count_nxt = count_r + 2'd1;
            end
            if (count_r >= 2'd2) begin
              err_nxt = 1'b1;
            end
            minus_nxt = 1'b0;
            whole_nxt = '0;
            frac_nxt  = '0;
            fcnt_nxt  = '0;
            if (q_item.kind == CK_SIGN) begin
              minus_nxt = q_item.minus;
              phase_nxt = PH_SIGN;
            end else if (q_item.kind == CK_DIGIT) begin
              whole_nxt = WHOLE_W'(q_item.digit);
              phase_nxt = PH_WHOLE;
            end else begin
              phase_nxt = PH_BAD;
            end
          end
          PH_SIGN, PH_WHOLE: begin
            if (q_item.kind == CK_DIGIT) begin
              whole_nxt = (whole_x10 > (WHOLE_W+5)'(WHOLE_SAT)) ?
                          WHOLE_W'(WHOLE_SAT) : whole_x10[WHOLE_W-1:0];
              phase_nxt = PH_WHOLE;
            end else if (q_item.kind == CK_POINT && phase_r == PH_WHOLE) begin
              phase_nxt = PH_POINT;
            end else begin
              phase_nxt = PH_BAD;
            end
          end
          PH_POINT, PH_FRAC: begin
            if (q_item.kind == CK_DIGIT && fcnt_r < FCNT_W'(FRAC_DIGITS)) begin
              frac_nxt  = frac_r + frac_add;
              fcnt_nxt  = fcnt_r + FCNT_W'(1);
              phase_nxt = PH_FRAC;
            end else begin
              phase_nxt = PH_BAD;
            end
          end
          default: begin
            phase_nxt = PH_BAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BETWEEN;
      count_r     <= '0;
      minus_r     <= 1'b0;
      whole_r     <= '0;
      frac_r      <= '0;
      fcnt_r      <= '0;
      err_r       <= 1'b0;
      sav_whole_r <= '0;
      sav_frac_r  <= '0;
      sav_minus_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      minus_r     <= minus_nxt;
      whole_r     <= whole_nxt;
      frac_r      <= frac_nxt;
      fcnt_r      <= fcnt_nxt;
      err_r       <= err_nxt;
      sav_whole_r <= sav_whole_nxt;
      sav_frac_r  <= sav_frac_nxt;
      sav_minus_r <= sav_minus_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    lat_r <= lat_nxt;
    lon_r <= lon_nxt;
  end

endmodule

// ===== sv/coordinate_pair_text_parser.sv =====
// After its end-of-line item is transferred, a result passes through the
// four-entry queue and then the parser into its output register.
// Throughput: one character per cycle while the queue is not full (in_stall);
// the output register lets the next line enter while a result waits.
// Reset: synchronous, active low; clears the queue, parser and output valid.
module coordinate_pair_text_parser
  import cptp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_character,
  input  logic                    in_end_of_line,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_valid_res,
  output logic signed [LAT_W-1:0] out_latitude,
  output logic signed [LON_W-1:0] out_longitude
);

  logic       q_full;
  logic       q_push;
  cptp_item_t q_push_item;
  logic       q_pop;
  logic       q_valid;
  cptp_item_t q_head;

  cptp_front u_front (
    .in_valid       (in_valid),
    .in_character   (in_character),
    .in_end_of_line (in_end_of_line),
    .in_stall       (in_stall),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_push_item)
  );

  cptp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  cptp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_latitude  (out_latitude),
    .out_longitude (out_longitude)
  );

endmodule

// ===== dv/testbench.sv =====
module testbench
  import cptp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    LEX_SPACE,
    LEX_SIGN,
    LEX_INT,
    LEX_DOT,
    LEX_FRAC,
    LEX_JUNK
  } lex_t;

  typedef struct {
    logic [7:0] ch;
    logic       eol;
    bit         drain;
  } char_item_t;

  typedef struct {
    logic                    ok;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } fix_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [7:0]              in_character = 8'h00;
  logic                    in_end_of_line = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_valid_res;
  logic signed [LAT_W-1:0] out_latitude;
  logic signed [LON_W-1:0] out_longitude;

  coordinate_pair_text_parser u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_character   (in_character),
    .in_end_of_line (in_end_of_line),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_valid_res  (out_valid_res),
    .out_latitude   (out_latitude),
    .out_longitude  (out_longitude)
  );

  // Line being parsed, as the block should see it.
  lex_t   lex;
  int     tokens;
  bit     neg;
  int     whole;
  longint frac;
  int     nfrac;
  bit     bad;
  longint kept_lat;

  char_item_t char_feed[$];
  fix_t       expected_fixes[$];
  logic [7:0] line_buf[$];

  int n_queued = 0;
  int n_taken  = 0;
  int n_lines  = 0;
  int n_good   = 0;
  int n_errors = 0;

  bit in_done   = 1'b0;
  int in_gap    = 0;
  bit in_rush   = 1'b0;
  bit out_armed = 1'b0;
  int out_hold  = 0;
  bit out_calm  = 1'b0;

  function automatic void clear_parser();
    lex      = LEX_SPACE;
    tokens   = 0;
    neg      = 1'b0;
    whole    = 0;
    frac     = 0;
    nfrac    = 0;
    bad      = 1'b0;
    kept_lat = 0;
  endfunction

  function automatic longint magnitude();
    longint f;
    int     d;
    f = frac;
    d = nfrac;
    while (d < FRAC_DIGITS) begin
      f = f * 10;
      d++;
    end
    return longint'(whole) * longint'(SCALE) + f;
  endfunction

  function automatic longint signed_value();
    longint m;
    m = magnitude();
    return (neg && m != 0) ? -m : m;
  endfunction

  function automatic void close_token();
    longint mag;
    longint lim;
    if (lex == LEX_SIGN || lex == LEX_JUNK) begin
      bad = 1'b1;
      return;
    end
    mag = magnitude();
    lim = longint'(tokens == 1 ? LAT_LIMIT : LON_LIMIT) * longint'(SCALE);
    if (mag > 64'sd2147483647 || mag > lim) begin
      bad = 1'b1;
      return;
    end
    if (tokens == 1) kept_lat = signed_value();
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Advances the parser by one transferred item; an end of line yields one fix.
  function automatic void predict_fix(input logic [7:0] c, input logic eol);
    fix_t e;
    int   w;
    if (eol) begin
      if (lex != LEX_SPACE) close_token();
      e.ok  = !bad && tokens == 2;
      e.lat = e.ok ? LAT_W'(kept_lat) : '0;
      e.lon = e.ok ? LON_W'(signed_value()) : '0;
      expected_fixes.push_back(e);
      n_lines++;
      if (e.ok) n_good++;
      clear_parser();
    end else if (c == CH_SPACE) begin
      if (lex != LEX_SPACE) begin
        close_token();
        lex = LEX_SPACE;
      end
    end else begin
      case (lex)
        LEX_SPACE: begin
          if (tokens < 3) tokens++;
          if (tokens == 3) bad = 1'b1;
          neg   = 1'b0;
          whole = 0;
          frac  = 0;
          nfrac = 0;
          if (c == CH_PLUS || c == CH_MINUS) begin
            neg = (c == CH_MINUS);
            lex = LEX_SIGN;
          end else if (is_digit(c)) begin
            whole = int'(c - CH_ZERO);
            lex   = LEX_INT;
          end else begin
            lex = LEX_JUNK;
          end
        end
        LEX_SIGN, LEX_INT: begin
          if (is_digit(c)) begin
            w     = whole * 10 + int'(c - CH_ZERO);
            whole = (w > WHOLE_SAT) ? WHOLE_SAT : w;
            lex   = LEX_INT;
          end else if (c == CH_POINT && lex == LEX_INT) begin
            lex = LEX_DOT;
          end else begin
            lex = LEX_JUNK;
          end
        end
        LEX_DOT, LEX_FRAC: begin
          if (is_digit(c) && nfrac < FRAC_DIGITS) begin
            frac = frac * 10 + longint'(c - CH_ZERO);
            nfrac++;
            lex = LEX_FRAC;
          end else begin
            lex = LEX_JUNK;
          end
        end
        default: lex = LEX_JUNK;
      endcase
    end
  endfunction

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Sender: one item per transfer, with a drawn gap after each.
  always @(negedge clk) begin
    char_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_done) begin
      in_done = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (char_feed.size() != 0 &&
                   !(char_feed[0].drain && expected_fixes.size() != 0)) begin
        nxt = char_feed.pop_front();
        in_character   <= nxt.ch;
        in_end_of_line <= nxt.eol;
        in_valid       <= 1'b1;
        if (nxt.eol) in_rush = ($urandom_range(0, 3) == 0);
        in_gap = in_rush ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a wait is drawn as each result shows up; some idle stalls too.
  always @(negedge clk) begin
    if (out_valid && !out_armed) begin
      out_armed = 1'b1;
      out_hold  = out_calm ? 0 : $urandom_range(0, 5);
    end
    if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !out_valid && !out_calm && ($urandom_range(0, 7) == 0);
    end
  end

  always @(posedge clk) begin
    fix_t e;
    if (!rst_n) begin
      clear_parser();
    end else begin
      if (in_valid && !in_stall) begin
        in_done = 1'b1;
        n_taken++;
        predict_fix(in_character, in_end_of_line);
      end
      if (out_valid && !out_stall) begin
        out_armed = 1'b0;
        out_calm  = ($urandom_range(0, 3) == 0);
        if (expected_fixes.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result: valid_res %0b latitude %0d longitude %0d",
                   $realtime, out_valid_res, out_latitude, out_longitude);
        end else begin
          e = expected_fixes.pop_front();
          if (out_valid_res !== e.ok) begin
            n_errors++;
            $display("%0t: valid_res expected %0b, got %0b", $realtime, e.ok, out_valid_res);
          end
          if (out_latitude !== e.lat) begin
            n_errors++;
            $display("%0t: latitude expected %0d, got %0d", $realtime, e.lat, out_latitude);
          end
          if (out_longitude !== e.lon) begin
            n_errors++;
            $display("%0t: longitude expected %0d, got %0d", $realtime, e.lon, out_longitude);
          end
        end
      end
    end
  end

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_digit();
    line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_spaces(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) line_buf.push_back(CH_SPACE);
  endtask

  task automatic send_line(input bit drain);
    char_item_t it;
    foreach (line_buf[i]) begin
      it.ch    = line_buf[i];
      it.eol   = 1'b0;
      it.drain = drain && i == 0;
      char_feed.push_back(it);
    end
    // The character lane carries noise on the end item.
    it.ch    = 8'($urandom_range(0, 255));
    it.eol   = 1'b1;
    it.drain = drain && line_buf.size() == 0;
    char_feed.push_back(it);
    n_queued += line_buf.size() + 1;
    line_buf.delete();
  endtask

  task automatic say(input string s);
    add_text(s);
    send_line(1'b0);
  endtask

  task automatic add_token(input int lim);
    int r;
    case ($urandom_range(0, 5))
      0: add_text("-");
      1: add_text("+");
      default: ;
    endcase
    r = $urandom_range(0, 9);
    if ($urandom_range(0, 7) == 0) add_text("0");
    if (r == 0) begin
      repeat ($urandom_range(4, 12)) add_digit();
    end else if (r == 1) begin
      add_text($sformatf("%0d", lim));
    end else begin
      add_text($sformatf("%0d", $urandom_range(0, lim)));
    end
    r = $urandom_range(0, 9);
    if (r >= 2) add_text(".");
    if (r == 3) begin
      repeat (FRAC_DIGITS + 1) add_digit();
    end else if (r == 4) begin
      repeat ($urandom_range(1, FRAC_DIGITS)) add_text("0");
    end else if (r > 4) begin
      repeat ($urandom_range(1, FRAC_DIGITS)) add_digit();
    end
  endtask

  task automatic random_line();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      add_spaces(0, 2);
      add_token(LAT_LIMIT);
      add_spaces(1, 3);
      add_token(LON_LIMIT);
      add_spaces(0, 2);
      // A share of the well-formed pairs get one byte spoilt or slipped in.
      if (r >= 70 && line_buf.size() != 0) begin
        n = $urandom_range(0, line_buf.size() - 1);
        if (r < 78) line_buf[n] = 8'($urandom_range(0, 255));
        else line_buf.insert(n, 8'($urandom_range(0, 255)));
      end
    end else if (r < 93) begin
      n = $urandom_range(0, 3);
      if (n >= 2) n++;
      for (int i = 0; i < n; i++) begin
        add_spaces(i == 0 ? 0 : 1, 2);
        add_token(LON_LIMIT);
      end
    end else begin
      repeat ($urandom_range(0, 14)) begin
        case ($urandom_range(0, 5))
          0: line_buf.push_back(CH_SPACE);
          1: line_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
          2: line_buf.push_back(CH_POINT);
          3, 4: add_digit();
          default: line_buf.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    send_line($urandom_range(0, 24) == 0);
  endtask

  initial begin
    say("90 180");
    say("-90.000000 -180.000000");
    say("-0 -0.000");
    say("12. +34.");
    say("90.000001 0");
    say("0 -180.000001");
    say("1.1234567 2");
    say("");
    say("45.5");
    say("1 2 3");
    say("+ 5");
    say(".5 5");
    say("1.2.3 4");
    say("-+1 2");
    say("99999999999 1");
    say("0 2147.483648");
    say("1a 2");
    say("1 2-");
    say("5 -.5");
    say("   12.5    -7.25   ");
    // A zero byte and an all-ones byte are ordinary characters that spoil a token.
    add_text("1");
    line_buf.push_back(8'h00);
    add_text(" 2");
    line_buf.push_back(8'hFF);
    send_line(1'b0);
    add_text("-89.999999 179.999999");
    send_line(1'b1);
    while (n_queued < 1450) random_line();

    while (n_taken != n_queued) @(posedge clk);
    while (expected_fixes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Run covered %0d transfers over %0d lines, %0d of them valid coordinate pairs.",
             n_taken, n_lines, n_good);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
